FILE: sv/ps2m_pkg.sv
`timescale 1ns / 1ps
// Package for the PS/2 mouse packet decoder: word types, codes and constants.
// Depends on nothing; the design files use it by scoped names, the testbench imports it.
package ps2m_pkg;

    // Configuration: mouse kinds.
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_WHEEL = 2'd1;
    localparam logic [1:0] KIND_FIVE  = 2'd2;

    // Input commands.
    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_SET_POS = 1'b1;

    // Byte-level constants of the mouse protocol.
    localparam logic [7:0] ACK_BYTE  = 8'hFA;
    localparam int         FRAME_BIT = 3;
    localparam logic [2:0] LEN_SHORT = 3'd3;
    localparam logic [2:0] LEN_LONG  = 3'd4;

    // Wheel codes of the five-button kind (low nibble of the fourth byte).
    localparam logic [3:0] WCODE_V_UP   = 4'h1;
    localparam logic [3:0] WCODE_H_RIGHT = 4'h2;
    localparam logic [3:0] WCODE_H_LEFT = 4'hE;
    localparam logic [3:0] WCODE_V_DOWN = 4'hF;

    // Result event kinds.
    localparam logic [1:0] EV_ACK    = 2'd0;
    localparam logic [1:0] EV_BUTTON = 2'd1;
    localparam logic [1:0] EV_MOVE   = 2'd2;
    localparam logic [1:0] EV_SCROLL = 2'd3;

    // Bit positions in a job's event mask, in the order results go out.
    localparam int NUM_EV_BITS = 8;
    localparam int NUM_BUTTONS = 5;
    localparam logic [2:0] EVB_ACK    = 3'd0;
    localparam logic [2:0] EVB_BTN0   = 3'd1;
    localparam logic [2:0] EVB_BTN4   = 3'd5;
    localparam logic [2:0] EVB_MOVE   = 3'd6;
    localparam logic [2:0] EVB_SCROLL = 3'd7;

    // Default depth of the job queue between the front and back parts.
    localparam int JOBQ_DEPTH = 2;

    typedef struct packed {
        logic              command;
        logic [7:0]        rx_byte;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [2:0]         button_id;
        logic               pressed;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [7:0]  delta_x;
        logic signed [7:0]  delta_y;
        logic signed [7:0]  scroll_h;
        logic signed [7:0]  scroll_v;
        logic [4:0]         buttons_held;
        logic               last;
    } t_out_word;

    // One classified input: which events it causes and what they carry.
    typedef struct packed {
        logic [NUM_EV_BITS-1:0] ev_mask;
        logic [NUM_BUTTONS-1:0] press;
        logic [NUM_BUTTONS-1:0] held;
        logic signed [31:0]     pos_x;
        logic signed [31:0]     pos_y;
        logic signed [7:0]      delta_x;
        logic signed [7:0]      delta_y;
        logic signed [7:0]      scroll_h;
        logic signed [7:0]      scroll_v;
    } t_job;

endpackage

FILE: sv/ps2m_front.sv
`timescale 1ns / 1ps
// Front part: frames mouse bytes into packets, keeps position and button state,
// and turns each input word into at most one job. Depends on ps2m_pkg.
module ps2m_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_wr_data,
    input  logic              i_accept,
    input  ps2m_pkg::t_in_word i_word,
    output logic              o_job_push,
    output ps2m_pkg::t_job    o_job
);

    logic [1:0]  r_kind;
    logic [2:0]  r_count, n_count;
    logic [7:0]  r_bytes [4];
    logic [4:0]  r_held, n_held;
    logic [31:0] r_abs_x, n_abs_x;
    logic [31:0] r_abs_y, n_abs_y;

    logic [1:0]  idx;
    logic [7:0]  rx, b0, dx, dy, b3;
    logic        is_ack, store_byte, framed_inc, pkt_done, five, scroll;
    logic [2:0]  cnt_cand, pkt_len;
    logic [4:0]  new_btn, changed;
    logic [31:0] sum_x, sum_y;
    logic [7:0]  sh, sv;

    always_comb begin
        rx         = i_word.rx_byte;
        idx        = r_count[1:0];
        is_ack     = (rx == ps2m_pkg::ACK_BYTE);
        store_byte = i_accept && (i_word.command == ps2m_pkg::CMD_RX_BYTE) && !is_ack;
        b0 = (idx == 2'd0) ? rx : r_bytes[0];
        dx = (idx == 2'd1) ? rx : r_bytes[1];
        dy = (idx == 2'd2) ? rx : r_bytes[2];
        b3 = (idx == 2'd3) ? rx : r_bytes[3];

        framed_inc = (r_count != 3'd0) || rx[ps2m_pkg::FRAME_BIT];
        cnt_cand   = framed_inc ? (r_count + 3'd1) : r_count;
        pkt_len    = ((r_kind == ps2m_pkg::KIND_WHEEL) || (r_kind == ps2m_pkg::KIND_FIVE))
                     ? ps2m_pkg::LEN_LONG : ps2m_pkg::LEN_SHORT;
        pkt_done   = (cnt_cand >= pkt_len);
        five       = (r_kind == ps2m_pkg::KIND_FIVE);

        // Button ids: left, middle, right, four, five.
        new_btn = {five ? b3[5] : r_held[4], five ? b3[4] : r_held[3], b0[1], b0[2], b0[0]};
        changed = new_btn ^ r_held;
        sum_x   = r_abs_x + {{24{dx[7]}}, dx};
        sum_y   = r_abs_y + {{24{dy[7]}}, dy};

        scroll = 1'b0;
        sh     = 8'd0;
        sv     = 8'd0;
        if (r_kind == ps2m_pkg::KIND_WHEEL) begin
            scroll = 1'b1;
            sv     = b3;
        end else if (five) begin
            case (b3[3:0])
                ps2m_pkg::WCODE_V_UP: begin
                    scroll = 1'b1;
                    sv     = 8'h01;
                end
                ps2m_pkg::WCODE_H_RIGHT: begin
                    scroll = 1'b1;
                    sh     = 8'h01;
                end
                ps2m_pkg::WCODE_H_LEFT: begin
                    scroll = 1'b1;
                    sh     = 8'hFF;
                end
                ps2m_pkg::WCODE_V_DOWN: begin
                    scroll = 1'b1;
                    sv     = 8'hFF;
                end
                default: begin
                    scroll = 1'b0;
                end
            endcase
        end

        n_count = r_count;
        n_held  = r_held;
        n_abs_x = r_abs_x;
        n_abs_y = r_abs_y;

        o_job_push     = 1'b0;
        o_job.ev_mask  = '0;
        o_job.press    = new_btn;
        o_job.held     = r_held;
        o_job.pos_x    = sum_x;
        o_job.pos_y    = sum_y;
        o_job.delta_x  = dx;
        o_job.delta_y  = dy;
        o_job.scroll_h = sh;
        o_job.scroll_v = sv;

        if (i_accept) begin
            if (i_word.command == ps2m_pkg::CMD_SET_POS) begin
                n_abs_x = i_word.new_x;
                n_abs_y = i_word.new_y;
            end else if (is_ack) begin
                o_job_push                      = 1'b1;
                o_job.ev_mask[ps2m_pkg::EVB_ACK] = 1'b1;
            end else begin
                n_count = cnt_cand;
                if (pkt_done) begin
                    n_count = 3'd0;
                    if (b0[ps2m_pkg::FRAME_BIT]) begin
                        n_held     = new_btn;
                        n_abs_x    = sum_x;
                        n_abs_y    = sum_y;
                        o_job.held = new_btn;
                        o_job.ev_mask[ps2m_pkg::EVB_BTN4:ps2m_pkg::EVB_BTN0] = changed;
                        o_job.ev_mask[ps2m_pkg::EVB_MOVE]   = (dx != 8'd0) || (dy != 8'd0);
                        o_job.ev_mask[ps2m_pkg::EVB_SCROLL] = scroll;
                        o_job_push = (o_job.ev_mask != '0);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= ps2m_pkg::KIND_PLAIN;
            r_count <= 3'd0;
            r_held  <= 5'd0;
            r_abs_x <= 32'd0;
            r_abs_y <= 32'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_kind <= i_cfg_wr_data;
            end
            r_count <= n_count;
            r_held  <= n_held;
            r_abs_x <= n_abs_x;
            r_abs_y <= n_abs_y;
        end
    end

    // Packet bytes need no reset: an entry is always written before it is read.
    always_ff @(posedge i_clk) begin
        if (store_byte) begin
            r_bytes[idx] <= rx;
        end
    end

endmodule

FILE: sv/ps2m_jobq.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of jobs between the front and back parts.
// Depends on ps2m_pkg for the job type.
module ps2m_jobq #(
    parameter int DEPTH = ps2m_pkg::JOBQ_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ps2m_pkg::t_job i_wdata,
    input  logic           i_pop,
    output ps2m_pkg::t_job o_rdata,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ps2m_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

FILE: sv/ps2m_back.sv
`timescale 1ns / 1ps
// Back part: walks the oldest job's event mask and sends one result word per
// cycle to the output register when it is free or popped. Depends on ps2m_pkg.
module ps2m_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ps2m_pkg::t_job     i_job,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output ps2m_pkg::t_out_word o_word
);

    logic [ps2m_pkg::NUM_EV_BITS-1:0] r_sent;
    logic [ps2m_pkg::NUM_EV_BITS-1:0] remaining, sel_onehot;
    logic [2:0]                        sel;
    logic                              r_out_valid, load, is_last;
    ps2m_pkg::t_out_word               r_out, res;

    always_comb begin
        remaining = i_job.ev_mask & ~r_sent;
        sel       = 3'd0;
        // Lowest pending event goes first.
        for (int i = ps2m_pkg::NUM_EV_BITS - 1; i >= 0; i--) begin
            if (remaining[i]) begin
                sel = 3'(i);
            end
        end
        sel_onehot = '0;
        sel_onehot[sel] = 1'b1;
        is_last = ((remaining & ~sel_onehot) == '0);

        res              = '0;
        res.buttons_held = i_job.held;
        res.last         = is_last;
        case (sel)
            ps2m_pkg::EVB_ACK: begin
                res.event_kind = ps2m_pkg::EV_ACK;
            end
            ps2m_pkg::EVB_MOVE: begin
                res.event_kind = ps2m_pkg::EV_MOVE;
                res.pos_x      = i_job.pos_x;
                res.pos_y      = i_job.pos_y;
                res.delta_x    = i_job.delta_x;
                res.delta_y    = i_job.delta_y;
            end
            ps2m_pkg::EVB_SCROLL: begin
                res.event_kind = ps2m_pkg::EV_SCROLL;
                res.delta_x    = i_job.delta_x;
                res.delta_y    = i_job.delta_y;
                res.scroll_h   = i_job.scroll_h;
                res.scroll_v   = i_job.scroll_v;
            end
            default: begin
                res.event_kind = ps2m_pkg::EV_BUTTON;
                res.button_id  = sel - ps2m_pkg::EVB_BTN0;
                res.pressed    = i_job.press[sel - ps2m_pkg::EVB_BTN0];
                res.delta_x    = i_job.delta_x;
                res.delta_y    = i_job.delta_y;
            end
        endcase

        load      = i_job_valid && (!r_out_valid || i_pop);
        o_job_pop = load && is_last;
    end

    assign o_empty = !r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sent      <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_sent      <= is_last ? '0 : (r_sent | sel_onehot);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

endmodule

FILE: sv/ps2_mouse_packet_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the PS/2 mouse packet decoder: front, job queue and back part.
// Depends on ps2m_pkg, ps2m_front, ps2m_jobq and ps2m_back.
//
// Usage. Input words enter through a queue-like port: a word is taken at a
// rising edge with push high and full low. A word either carries a byte
// received from the mouse or loads the absolute position. Results leave the
// same way: while empty is low the oldest result word sits on o_out_word, and
// pop high at a rising edge takes it. The last result of each input word has
// its last flag set. The mouse kind register is written through i_cfg_wr_en
// and i_cfg_wr_data while the block is idle.
//
// Timing. The front part classifies a word at the edge that accepts it and puts
// any job it makes in the job queue; a new word can be taken every cycle while
// the queue has room. From the queue the back part moves each result into the
// output register when that register is empty or being popped. The back part
// sends one result per cycle while the receiver pops: a packet byte yields one
// to seven results, and words without results place no job in the queue.
// A stalled receiver holds the output register, the job queue fills and full
// rises. Reset clears framing, buttons, position, the kind register and both
// queues; empty is high and full low after reset.
module ps2_mouse_packet_decoder_unit #(
    parameter int JOBQ_DEPTH = ps2m_pkg::JOBQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  logic                push,
    output logic                full,
    input  ps2m_pkg::t_in_word  i_in_word,
    output logic                empty,
    input  logic                pop,
    output ps2m_pkg::t_out_word o_out_word
);

    logic           accept;
    logic           job_push, job_pop, jobq_empty;
    ps2m_pkg::t_job front_job, head_job;

    // The front part only takes a word when the job queue has room for its job.
    assign accept = push && !full;

    ps2m_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_word        (i_in_word),
        .o_job_push    (job_push),
        .o_job         (front_job)
    );

    ps2m_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata (front_job),
        .i_pop   (job_pop),
        .o_rdata (head_job),
        .o_empty (jobq_empty),
        .o_full  (full)
    );

    ps2m_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (!jobq_empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_word      (o_out_word)
    );

`ifndef SYNTH
    // An acknowledge is always the only result of its input word.
    a_ack_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.event_kind == ps2m_pkg::EV_ACK) |-> o_out_word.last)
        else $error("acknowledge result without last flag");

    // Button events name only the five existing buttons.
    a_button_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.event_kind == ps2m_pkg::EV_BUTTON)
        |-> (o_out_word.button_id <= 3'd4))
        else $error("button event with invalid button id");

    // Leaving reset, both queues start empty.
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("queues not cleared by reset");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ps2_mouse_packet_decoder_unit: directed and random byte streams.
// A local event predictor checks every result word in order. Needs ps2m_pkg and the block's RTL.
module tb_top;
    import ps2m_pkg::*;

    // Kind 3 is not named by the package. The block frames it like the plain kind.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int DIRECTED_WORDS = 25;
    localparam int RANDOM_WORDS   = 450;
    // Settling time before a kind write: the sender waits this long with no word
    // taken and no event due, so that no job is still in flight.
    localparam int SETTLE_CYCLES  = 10;
    // Correct pauses without a handshake come from a receiver stall, a sender gap
    // or a settle wait; the limit lies far above the longest of them.
    localparam int STUCK_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [1:0] {ACT_WORD, ACT_KIND, ACT_SETTLE} t_act;
    typedef struct {
        t_act       act;
        t_in_word   word;
        logic [1:0] kind;
    } t_plan_step;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      cfg_en = 1'b0;
    logic [1:0] cfg_data = '0;
    logic      push = 1'b0;
    logic      full;
    t_in_word  in_word = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_word out_word;

    ps2_mouse_packet_decoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_en),
        .i_cfg_wr_data(cfg_data),
        .push         (push),
        .full         (full),
        .i_in_word    (in_word),
        .empty        (empty),
        .pop          (pop),
        .o_out_word   (out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Words and kind writes waiting to be sent, and the events still due.
    t_plan_step word_plan[$];
    t_out_word  due_events[$];
    t_out_word  fresh_events[$];

    // Predicted block state.
    logic [1:0]  kind_now = KIND_PLAIN;
    logic [2:0]  frame_cnt = '0;
    logic [7:0]  frame_bytes[4];
    logic [4:0]  held_mask = '0;
    logic [31:0] pos_x = '0;
    logic [31:0] pos_y = '0;

    int words_planned = 0;
    int words_sent = 0;
    int events_seen = 0;
    int events_by_kind[4] = '{0, 0, 0, 0};
    int mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("tb_top: mismatch at result %0d: %s", events_seen, msg);
        mismatch_count++;
    endtask

    // One press or release event when the button's state changes.
    task automatic button_event(input int id, input logic now, input logic [7:0] dx,
                                input logic [7:0] dy);
        t_out_word ev;
        if (now == held_mask[id])
            return;
        held_mask[id] = now;
        ev = '0;
        ev.event_kind = EV_BUTTON;
        ev.button_id  = 3'(id);
        ev.pressed    = now;
        ev.delta_x    = dx;
        ev.delta_y    = dy;
        fresh_events.push_back(ev);
    endtask

    // Works out the events one accepted word causes and queues them as due.
    task automatic decode_word(input t_in_word w);
        t_out_word  ev;
        logic [2:0] need;
        logic [7:0] b0, dx, dy, b3, sh, sv;
        logic       scroll_on;
        int         k;
        fresh_events.delete();
        if (w.command == CMD_SET_POS) begin
            pos_x = w.new_x;
            pos_y = w.new_y;
            return;
        end
        if (w.rx_byte == ACK_BYTE) begin
            ev = '0;
            ev.event_kind = EV_ACK;
            fresh_events.push_back(ev);
        end else begin
            // An unframed first byte is stored but not counted, so the next one replaces it.
            frame_bytes[frame_cnt[1:0]] = w.rx_byte;
            if (frame_cnt != 3'd0 || w.rx_byte[FRAME_BIT])
                frame_cnt = frame_cnt + 3'd1;
            need = (kind_now == KIND_WHEEL || kind_now == KIND_FIVE) ? LEN_LONG : LEN_SHORT;
            if (frame_cnt >= need) begin
                frame_cnt = '0;
                b0 = frame_bytes[0];
                dx = frame_bytes[1];
                dy = frame_bytes[2];
                b3 = frame_bytes[3];
                if (b0[FRAME_BIT]) begin
                    button_event(0, b0[0], dx, dy);
                    button_event(1, b0[2], dx, dy);
                    button_event(2, b0[1], dx, dy);
                    if (kind_now == KIND_FIVE) begin
                        button_event(3, b3[4], dx, dy);
                        button_event(4, b3[5], dx, dy);
                    end
                    // Sign and overflow bits of the first byte play no part here.
                    pos_x = pos_x + {{24{dx[7]}}, dx};
                    pos_y = pos_y + {{24{dy[7]}}, dy};
                    if (dx != 8'd0 || dy != 8'd0) begin
                        ev = '0;
                        ev.event_kind = EV_MOVE;
                        ev.pos_x   = pos_x;
                        ev.pos_y   = pos_y;
                        ev.delta_x = dx;
                        ev.delta_y = dy;
                        fresh_events.push_back(ev);
                    end
                    scroll_on = 1'b0;
                    sh = '0;
                    sv = '0;
                    if (kind_now == KIND_WHEEL) begin
                        scroll_on = 1'b1;
                        sv = b3;
                    end else if (kind_now == KIND_FIVE) begin
                        scroll_on = 1'b1;
                        case (b3[3:0])
                            WCODE_V_UP:    sv = 8'h01;
                            WCODE_H_RIGHT: sh = 8'h01;
                            WCODE_H_LEFT:  sh = 8'hFF;
                            WCODE_V_DOWN:  sv = 8'hFF;
                            default:       scroll_on = 1'b0;
                        endcase
                    end
                    if (scroll_on) begin
                        ev = '0;
                        ev.event_kind = EV_SCROLL;
                        ev.delta_x  = dx;
                        ev.delta_y  = dy;
                        ev.scroll_h = sh;
                        ev.scroll_v = sv;
                        fresh_events.push_back(ev);
                    end
                end
            end
        end
        // Every event of a word carries the mask as it stands after the whole word.
        for (k = 0; k < fresh_events.size(); k++) begin
            ev = fresh_events[k];
            ev.buttons_held = held_mask;
            ev.last = (k == fresh_events.size() - 1);
            due_events.push_back(ev);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
    endtask

    task automatic compare_event(input t_out_word got, input t_out_word want);
        check_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
        check_field("button_id", 32'(got.button_id), 32'(want.button_id));
        check_field("pressed", 32'(got.pressed), 32'(want.pressed));
        check_field("pos_x", got.pos_x, want.pos_x);
        check_field("pos_y", got.pos_y, want.pos_y);
        check_field("delta_x", 32'(got.delta_x), 32'(want.delta_x));
        check_field("delta_y", 32'(got.delta_y), 32'(want.delta_y));
        check_field("scroll_h", 32'(got.scroll_h), 32'(want.scroll_h));
        check_field("scroll_v", 32'(got.scroll_v), 32'(want.scroll_v));
        check_field("buttons_held", 32'(got.buttons_held), 32'(want.buttons_held));
        check_field("last", 32'(got.last), 32'(want.last));
    endtask

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int pick_pause(input bit calm, input int longest);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, longest);
    endfunction

    // Sender: one word in flight at a time, kind writes only once the block is quiet.
    int   send_gap = 0;
    int   quiet_cycles = 0;
    bit   send_calm = 1'b0;
    always @(posedge i_clk) begin : send_proc
        logic       took;
        logic       nxt_push;
        t_in_word   nxt_word;
        logic       nxt_cfg_en;
        logic [1:0] nxt_cfg_data;
        if (!i_rst_n) begin
            push   <= 1'b0;
            cfg_en <= 1'b0;
        end else begin
            took = push && !full;
            nxt_push = push;
            nxt_word = in_word;
            nxt_cfg_en = 1'b0;
            nxt_cfg_data = cfg_data;
            if (took) begin
                decode_word(in_word);
                words_sent++;
                nxt_push = 1'b0;
                if ($urandom_range(0, 59) == 0)
                    send_calm = !send_calm;
                send_gap = pick_pause(send_calm, 30);
            end
            if (took || due_events.size() != 0)
                quiet_cycles = 0;
            else if (quiet_cycles < SETTLE_CYCLES)
                quiet_cycles++;
            if (!nxt_push) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (word_plan.size() != 0) begin
                    case (word_plan[0].act)
                        ACT_WORD: begin
                            nxt_push = 1'b1;
                            nxt_word = word_plan[0].word;
                            void'(word_plan.pop_front());
                        end
                        ACT_KIND: begin
                            if (due_events.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                                nxt_cfg_en = 1'b1;
                                nxt_cfg_data = word_plan[0].kind;
                                kind_now = word_plan[0].kind;
                                void'(word_plan.pop_front());
                            end
                        end
                        default: begin
                            if (due_events.size() == 0)
                                void'(word_plan.pop_front());
                        end
                    endcase
                end
            end
            push     <= nxt_push;
            in_word  <= nxt_word;
            cfg_en   <= nxt_cfg_en;
            cfg_data <= nxt_cfg_data;
        end
    end

    // Receiver: takes result words with random stalls and checks each one.
    int sink_stall = 0;
    bit sink_calm = 1'b0;
    always @(posedge i_clk) begin : sink_proc
        t_out_word want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (due_events.size() == 0) begin
                    report_mismatch("result word with no event due");
                end else begin
                    want = due_events.pop_front();
                    compare_event(out_word, want);
                end
                events_by_kind[out_word.event_kind]++;
                events_seen++;
                if ($urandom_range(0, 79) == 0)
                    sink_calm = !sink_calm;
                sink_stall = pick_pause(sink_calm, 40);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Ends the run if neither side nor the kind register moves for too long.
    int stuck_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || cfg_en)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb_top: no handshake for %0d cycles, %0d events still due",
                         stuck_cycles, due_events.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic plan_word(input logic cmd, input logic [7:0] b, input logic [31:0] x,
                             input logic [31:0] y);
        t_plan_step s;
        s.act = ACT_WORD;
        s.kind = '0;
        s.word.command = cmd;
        s.word.rx_byte = b;
        s.word.new_x = x;
        s.word.new_y = y;
        word_plan.push_back(s);
        words_planned++;
    endtask

    // A byte word carries random position fields, which the block must ignore.
    task automatic plan_byte(input logic [7:0] b);
        plan_word(CMD_RX_BYTE, b, $urandom, $urandom);
    endtask

    task automatic plan_position(input logic [31:0] x, input logic [31:0] y);
        plan_word(CMD_SET_POS, 8'($urandom), x, y);
    endtask

    task automatic plan_kind(input logic [1:0] k);
        t_plan_step s;
        s.act = ACT_KIND;
        s.word = '0;
        s.kind = k;
        word_plan.push_back(s);
    endtask

    task automatic plan_settle();
        t_plan_step s;
        s.act = ACT_SETTLE;
        s.word = '0;
        s.kind = '0;
        word_plan.push_back(s);
    endtask

    // A framed packet with random content, cut short after keep bytes.
    task automatic plan_packet(input logic [1:0] k, input int keep);
        logic [7:0] pkt[4];
        logic [3:0] codes[4];
        int         len;
        int         i;
        codes = '{WCODE_V_UP, WCODE_H_RIGHT, WCODE_H_LEFT, WCODE_V_DOWN};
        len = (k == KIND_WHEEL || k == KIND_FIVE) ? 4 : 3;
        pkt[0] = 8'($urandom) | 8'h08;
        pkt[1] = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
        pkt[2] = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
        pkt[3] = 8'($urandom);
        if (k == KIND_FIVE && $urandom_range(0, 1) == 1)
            pkt[3][3:0] = codes[$urandom_range(0, 3)];
        for (i = 0; i < len && i < keep; i++) begin
            if ($urandom_range(0, 29) == 0)
                plan_byte(ACK_BYTE);
            plan_byte(pkt[i]);
        end
    endtask

    initial begin : stimulus
        logic [1:0] phase_kinds[4];
        logic [1:0] k;
        int         phase;
        int         quota;
        int         r;
        phase_kinds = '{KIND_FIVE, KIND_PLAIN, KIND_WHEEL, KIND_SPARE};

        // Plain kind after reset: acknowledge, position at its extremes so the
        // first move wraps, an unframed byte that must be dropped.
        plan_byte(ACK_BYTE);
        plan_position(32'h7FFF_FFFF, 32'h8000_0000);
        plan_byte(8'h0F);
        plan_byte(8'h7F);
        plan_byte(8'h80);
        plan_byte(8'h00);
        // Wheel kind: sign and overflow bits set, an acknowledge inside the
        // packet, the most negative wheel byte.
        plan_kind(KIND_WHEEL);
        plan_byte(8'hF9);
        plan_byte(ACK_BYTE);
        plan_byte(8'hFF);
        plan_byte(8'h01);
        plan_byte(8'h80);
        // Five buttons: buttons four and five pressed and released, two wheel codes.
        plan_kind(KIND_FIVE);
        plan_byte(8'h08);
        plan_byte(8'h00);
        plan_byte(8'h00);
        plan_byte(8'h31);
        plan_byte(8'h0A);
        plan_byte(8'h01);
        plan_byte(8'h00);
        plan_byte(8'h0E);
        // Reserved kind frames three bytes.
        plan_kind(KIND_SPARE);
        plan_byte(8'h0C);
        plan_byte(8'h10);
        plan_byte(8'h20);
        // Kind change inside a packet: two bytes as wheel, the third as plain.
        plan_kind(KIND_WHEEL);
        plan_byte(8'h0C);
        plan_byte(8'h05);
        plan_kind(KIND_PLAIN);
        plan_byte(8'h03);

        // Random phases: each starts with a kind write, most words are whole packets.
        phase = 0;
        while (words_planned < DIRECTED_WORDS + RANDOM_WORDS) begin
            k = (phase < 4) ? phase_kinds[phase] : 2'($urandom_range(0, 3));
            plan_kind(k);
            if (phase == 1)
                plan_settle();
            quota = words_planned + $urandom_range(40, 80);
            while (words_planned < quota) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    plan_settle();
                else if (r < 72)
                    plan_packet(k, 4);
                else if (r < 80)
                    plan_position($urandom, $urandom);
                else if (r < 86)
                    plan_byte(ACK_BYTE);
                else if (r < 92)
                    plan_byte(8'($urandom) & 8'hF7);
                else
                    plan_packet(k, $urandom_range(1, 2));
            end
            phase++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_plan.size() != 0 || push)
            @(posedge i_clk);
        while (due_events.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (due_events.size() != 0)
            report_mismatch($sformatf("%0d predicted events never came", due_events.size()));
        $display("tb_top: %0d words sent over %0d kind phases, %0d results checked", words_sent,
                 phase, events_seen);
        $display("tb_top: acknowledge %0d, button %0d, move %0d, scroll %0d, mismatches %0d",
                 events_by_kind[EV_ACK], events_by_kind[EV_BUTTON], events_by_kind[EV_MOVE],
                 events_by_kind[EV_SCROLL], mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/ps2m_pkg.sv
sv/ps2m_front.sv
sv/ps2m_jobq.sv
sv/ps2m_back.sv
sv/ps2_mouse_packet_decoder_unit.sv
sim/tb_top.sv
